/* rtl/core/mmn_pkg.sv */
`default_nettype none
package mmn_pkg;

  localparam int COORD_W = 32;
  localparam int NORM_W  = 17;
  localparam int IDX_W   = 6;

  // One quotient bit per divider step; the quotient is at most 1.0 in Q1.16.
  localparam int DIV_STEPS = NORM_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV
  } mmn_state_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic div_start;
    logic emit;
    logic clear;
    logic idx_inc;
  } mmn_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
  } mmn_sts_t;

endpackage
`default_nettype wire

/* rtl/core/min_max_normalize_2d.sv */
`default_nettype none
// Min-max normalization of a set of 2D points. Points (signed Q16.16) are
// transferred one per cycle with start while busy is low; up to DEPTH are stored and
// the rest are dropped and reported through overflow. The transfer of a point with
// final_point high raises busy and starts the emission of every stored point in
// arrival order, each axis rescaled to unsigned Q1.16 with truncation. Each result
// is held on the result ports for one cycle with valid high; the receiver cannot
// stall. Emission of each stored point takes one memory read, one operand load
// and the 17-step shift-subtract divider of each axis; busy falls in the cycle
// the last result appears.
module min_max_normalize_2d
  import mmn_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [COORD_W-1:0] coord_x,
  input  wire logic signed [COORD_W-1:0] coord_y,
  input  wire logic                      final_point,
  output logic                           valid,
  output logic             [IDX_W-1:0]   point_index,
  output logic             [NORM_W-1:0]  norm_x,
  output logic             [NORM_W-1:0]  norm_y,
  output logic                           flat_x,
  output logic                           flat_y,
  output logic                           overflow,
  output logic                           end_of_run
);

  mmn_cmd_t cmd;
  mmn_sts_t sts;

  mmn_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .final_point (final_point),
    .sts         (sts),
    .busy        (busy),
    .cmd         (cmd)
  );

  mmn_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .sts         (sts),
    .valid       (valid),
    .point_index (point_index),
    .norm_x      (norm_x),
    .norm_y      (norm_y),
    .flat_x      (flat_x),
    .flat_y      (flat_y),
    .overflow    (overflow),
    .end_of_run  (end_of_run)
  );

endmodule
`default_nettype wire

/* rtl/core/mmn_ram.sv */
`default_nettype none
module mmn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mmn_div.sv */
`default_nettype none
module mmn_div
  import mmn_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [COORD_W-1:0] num,
  input  wire logic [COORD_W-1:0] den,
  output logic                    done,
  output logic [NORM_W-1:0]       quo
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [COORD_W:0]   rem;
  logic [CNT_W-1:0]   cnt;
  logic               active;
  logic               ge;
  logic [COORD_W:0]   rem_sub;

  // Shift-subtract long division of num * 2^16 by den. Since num <= den, the
  // partial remainder always stays below twice den and fits one extra bit.
  assign ge      = rem >= {1'b0, den};
  assign rem_sub = ge ? (rem - {1'b0, den}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= !start && active && cnt == '0;
      if (start) begin
        active <= 1'b1;
      end else if (active && cnt == '0) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      cnt <= CNT_W'(DIV_STEPS - 1);
      quo <= '0;
    end else if (active) begin
      rem <= {rem_sub[COORD_W-1:0], 1'b0};
      cnt <= cnt - 1'b1;
      quo <= {quo[NORM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/mmn_ctrl.sv */
`default_nettype none
module mmn_ctrl
  import mmn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire logic     final_point,
  input  wire mmn_sts_t sts,
  output logic          busy,
  output mmn_cmd_t      cmd
);

  mmn_state_t state;
  mmn_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && final_point) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = sts.last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_READ: cmd.read = 1'b1;
      ST_LOAD: cmd.div_start = 1'b1;
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.emit    = 1'b1;
          cmd.clear   = sts.last;
          cmd.idx_inc = !sts.last;
        end
      end
      default: busy = 1'b1;
    endcase
  end

  // Emission only ever begins with the transfer of a final point.
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && final_point))
    else $error("emission began without a final point");

endmodule
`default_nettype wire

/* rtl/core/mmn_datapath.sv */
`default_nettype none
module mmn_datapath
  import mmn_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mmn_cmd_t           cmd,
  input  wire logic [COORD_W-1:0] coord_x,
  input  wire logic [COORD_W-1:0] coord_y,
  output mmn_sts_t                sts,
  output logic                    valid,
  output logic [IDX_W-1:0]        point_index,
  output logic [NORM_W-1:0]       norm_x,
  output logic [NORM_W-1:0]       norm_y,
  output logic                    flat_x,
  output logic                    flat_y,
  output logic                    overflow,
  output logic                    end_of_run
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count;
  logic [AW-1:0]      idx;
  logic               dropped;
  logic [COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic               full;
  logic               store;
  logic               first;
  logic [COORD_W-1:0] rdata_x, rdata_y;
  logic [COORD_W:0]   num_x, num_y;
  logic [COORD_W-1:0] den_x, den_y;
  logic               is_flat_x, is_flat_y;
  logic               done_x, done_y;
  logic [NORM_W-1:0]  quo_x, quo_y;

  assign full  = count == CW'(DEPTH);
  assign store = cmd.accept && !full;
  assign first = count == '0;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count   <= '0;
      dropped <= 1'b0;
      min_x   <= '0;
      max_x   <= '0;
      min_y   <= '0;
      max_y   <= '0;
    end else if (cmd.accept) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + 1'b1;
        if (first || $signed(coord_x) < $signed(min_x)) min_x <= coord_x;
        if (first || $signed(coord_x) > $signed(max_x)) max_x <= coord_x;
        if (first || $signed(coord_y) < $signed(min_y)) min_y <= coord_y;
        if (first || $signed(coord_y) > $signed(max_y)) max_y <= coord_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  mmn_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (store),
    .waddr (count[AW-1:0]),
    .wdata (coord_x),
    .re    (cmd.read),
    .raddr (idx),
    .rdata (rdata_x)
  );

  mmn_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_ram_y (
    .clk   (clk),
    .we    (store),
    .waddr (count[AW-1:0]),
    .wdata (coord_y),
    .re    (cmd.read),
    .raddr (idx),
    .rdata (rdata_y)
  );

  // Differences of two signed 32-bit values are nonnegative here and fit 32 bits.
  assign num_x     = {rdata_x[COORD_W-1], rdata_x} - {min_x[COORD_W-1], min_x};
  assign num_y     = {rdata_y[COORD_W-1], rdata_y} - {min_y[COORD_W-1], min_y};
  assign den_x     = max_x - min_x;
  assign den_y     = max_y - min_y;
  assign is_flat_x = max_x == min_x;
  assign is_flat_y = max_y == min_y;

  mmn_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num_x[COORD_W-1:0]),
    .den   (den_x),
    .done  (done_x),
    .quo   (quo_x)
  );

  mmn_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num_y[COORD_W-1:0]),
    .den   (den_y),
    .done  (done_y),
    .quo   (quo_y)
  );

  assign sts.div_done = done_x;
  assign sts.last     = (CW'(idx) + 1'b1) == count;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  // The result registers capture the set's flags on the same edge that clears them.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      point_index <= IDX_W'(idx);
      norm_x      <= is_flat_x ? '0 : quo_x;
      norm_y      <= is_flat_y ? '0 : quo_y;
      flat_x      <= is_flat_x;
      flat_y      <= is_flat_y;
      overflow    <= dropped;
      end_of_run  <= sts.last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) done_x == done_y)
    else $error("axis dividers out of step");

  assert property (@(posedge clk) disable iff (rst)
    valid && end_of_run |-> count == '0 && !dropped)
    else $error("set not cleared after its last result");

  assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> CW'(idx) < count)
    else $error("read of an entry beyond the stored points");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
  import mmn_pkg::*;

  localparam int DEPTH = 64;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
    logic              fx;
    logic              fy;
    logic              ov;
    logic              eor;
  } norm_result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      fin;
    logic                      typed;
    norm_result_t              last_res;
  } point_row_t;

  typedef enum int {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_FLAT,
    SPREAD_EXTREME
  } spread_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic                      final_point = 1'b0;
  logic                      busy;
  logic                      valid;
  logic [IDX_W-1:0]          point_index;
  logic [NORM_W-1:0]         norm_x;
  logic [NORM_W-1:0]         norm_y;
  logic                      flat_x;
  logic                      flat_y;
  logic                      overflow;
  logic                      end_of_run;

  // Travels with each point so that a typed-in expectation replaces the predicted
  // last result of the set that the point closes.
  logic                      row_typed = 1'b0;
  norm_result_t              row_last = '0;

  // Predictor state.
  logic signed [COORD_W-1:0] stored_x [DEPTH];
  logic signed [COORD_W-1:0] stored_y [DEPTH];
  logic signed [COORD_W-1:0] lo_x = '0, hi_x = '0, lo_y = '0, hi_y = '0;
  int                        n_stored = 0;
  logic                      points_dropped = 1'b0;
  norm_result_t              pending_norms [$];
  int                        err_count = 0;

  point_row_t directed_rows [20] = '{
    '{32'sd0, 32'sd0, 1'b1, 1'b1, '{6'd0, 17'd0, 17'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{COORD_MIN, COORD_MAX, 1'b0, 1'b0, '0},
    '{COORD_MAX, COORD_MIN, 1'b1, 1'b1, '{6'd1, 17'd65536, 17'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{-32'sd65536, 32'sd7, 1'b0, 1'b0, '0},
    '{32'sh0010_0000, 32'sd7, 1'b0, 1'b0, '0},
    '{32'sd2, 32'sd7, 1'b1, 1'b0, '0},
    '{32'sd100, -32'sd100, 1'b0, 1'b0, '0},
    '{32'sd50, -32'sd50, 1'b0, 1'b0, '0},
    '{32'sd200, -32'sd300, 1'b0, 1'b0, '0},
    '{32'sd100, -32'sd100, 1'b1, 1'b0, '0},
    '{32'sd5, 32'sd5, 1'b0, 1'b0, '0},
    '{32'sd5, 32'sd5, 1'b1, 1'b1, '{6'd1, 17'd0, 17'd0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{-32'sd1, 32'sd0, 1'b0, 1'b0, '0},
    '{32'sd0, 32'sd1, 1'b0, 1'b0, '0},
    '{32'sd1, -32'sd1, 1'b1, 1'b0, '0},
    '{COORD_MAX, 32'sd0, 1'b0, 1'b0, '0},
    '{COORD_MIN, 32'sd0, 1'b1, 1'b1, '{6'd1, 17'd0, 17'd0, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{32'sd0, 32'sd0, 1'b0, 1'b0, '0},
    '{32'sd3, COORD_MAX, 1'b0, 1'b0, '0},
    '{32'sd1, COORD_MIN, 1'b1, 1'b0, '0}
  };

  min_max_normalize_2d #(
    .DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .final_point(final_point),
    .valid      (valid),
    .point_index(point_index),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .flat_x     (flat_x),
    .flat_y     (flat_y),
    .overflow   (overflow),
    .end_of_run (end_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [NORM_W-1:0] scale_to_unit(logic signed [COORD_W-1:0] v,
                                                       logic signed [COORD_W-1:0] lo,
                                                       logic signed [COORD_W-1:0] hi);
    logic [63:0] num, den;
    num = 64'(longint'(v) - longint'(lo));
    den = 64'(longint'(hi) - longint'(lo));
    if (den == 0) return '0;
    return NORM_W'((num << 16) / den);
  endfunction

  // Takes one transferred point into the set; a final point emits the whole set.
  function automatic void absorb_point(logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y, logic fin);
    norm_result_t r;
    logic fx, fy;
    if (n_stored < DEPTH) begin
      if (n_stored == 0) begin
        lo_x = x;
        hi_x = x;
        lo_y = y;
        hi_y = y;
      end else begin
        if (x < lo_x) lo_x = x;
        if (x > hi_x) hi_x = x;
        if (y < lo_y) lo_y = y;
        if (y > hi_y) hi_y = y;
      end
      stored_x[n_stored] = x;
      stored_y[n_stored] = y;
      n_stored++;
    end else begin
      points_dropped = 1'b1;
    end
    if (!fin) return;
    fx = (hi_x == lo_x);
    fy = (hi_y == lo_y);
    for (int i = 0; i < n_stored; i++) begin
      r.idx = IDX_W'(i);
      r.nx  = fx ? '0 : scale_to_unit(stored_x[i], lo_x, hi_x);
      r.ny  = fy ? '0 : scale_to_unit(stored_y[i], lo_y, hi_y);
      r.fx  = fx;
      r.fy  = fy;
      r.ov  = points_dropped;
      r.eor = (i == n_stored - 1);
      if (r.eor && row_typed) r = row_last;
      pending_norms.push_back(r);
    end
    n_stored = 0;
    points_dropped = 1'b0;
    lo_x = '0;
    hi_x = '0;
    lo_y = '0;
    hi_y = '0;
  endfunction

  function automatic void compare_field(string name, logic [NORM_W-1:0] want,
                                        logic [NORM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  function automatic void check_result();
    norm_result_t want;
    if (pending_norms.size() == 0) begin
      $error("result with nothing expected: point_index %0d", point_index);
      err_count++;
      return;
    end
    want = pending_norms.pop_front();
    compare_field("point_index", NORM_W'(want.idx), NORM_W'(point_index));
    compare_field("norm_x", want.nx, norm_x);
    compare_field("norm_y", want.ny, norm_y);
    compare_field("flat_x", NORM_W'(want.fx), NORM_W'(flat_x));
    compare_field("flat_y", NORM_W'(want.fy), NORM_W'(flat_y));
    compare_field("overflow", NORM_W'(want.ov), NORM_W'(overflow));
    compare_field("end_of_run", NORM_W'(want.eor), NORM_W'(end_of_run));
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (valid === 1'b1) check_result();
      if (start && busy === 1'b0) absorb_point(coord_x, coord_y, final_point);
    end
  end

  function automatic spread_t pick_spread();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return SPREAD_FULL;
    if (r < 7) return SPREAD_NARROW;
    if (r == 7) return SPREAD_FLAT;
    return SPREAD_EXTREME;
  endfunction

  function automatic logic signed [COORD_W-1:0] gen_coord(spread_t mode,
                                                          logic signed [COORD_W-1:0] base);
    case (mode)
      SPREAD_FULL:   return $urandom;
      SPREAD_NARROW: return base + COORD_W'($urandom_range(4000)) - 32'sd2000;
      SPREAD_FLAT:   return base;
      default: begin
        case ($urandom_range(4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          3: return -32'sd1;
          default: return base;
        endcase
      end
    endcase
  endfunction

  // Holds one point on the inputs until it is transferred, then maybe idles.
  task automatic drive_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic fin, logic typed, norm_result_t res, int idle_pct);
    int gap;
    coord_x     <= x;
    coord_y     <= y;
    final_point <= fin;
    row_typed   <= typed;
    row_last    <= res;
    start       <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      start       <= 1'b0;
      coord_x     <= $urandom;
      coord_y     <= $urandom;
      final_point <= $urandom_range(1);
      row_typed   <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_norms.size() != 0) @(posedge clk);
  endtask

  initial begin
    int idle_pct, phase_items, set_no, set_size;
    spread_t mode_x, mode_y;
    logic signed [COORD_W-1:0] base_x, base_y;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      drive_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].fin,
                  directed_rows[i].typed, directed_rows[i].last_res, 10);
    end

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 10 : (phase == 1) ? 66 : 0;
      hold_for_results();
      phase_items = 0;
      set_no = 0;
      while (phase_items < 100) begin
        // The first set of phase 0 overruns the store (the final point is dropped);
        // the first set of phase 1 fills it exactly.
        if (phase == 0 && set_no == 0) set_size = $urandom_range(DEPTH + 1, DEPTH + 4);
        else if (phase == 1 && set_no == 0) set_size = DEPTH;
        else if ($urandom_range(9) == 0) set_size = $urandom_range(DEPTH - 4, DEPTH + 6);
        else set_size = $urandom_range(1, 10);
        mode_x = pick_spread();
        mode_y = pick_spread();
        base_x = $urandom;
        base_y = $urandom;
        for (int k = 0; k < set_size; k++) begin
          drive_point(gen_coord(mode_x, base_x), gen_coord(mode_y, base_y),
                      k == set_size - 1, 1'b0, '0, idle_pct);
        end
        phase_items += set_size;
        set_no++;
        if ($urandom_range(7) == 0) hold_for_results();
      end
    end

    hold_for_results();
    repeat (60) @(posedge clk);
    if (pending_norms.size() != 0) begin
      $error("%0d expected results never arrived", pending_norms.size());
      err_count++;
    end
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #16_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* min_max_normalize_2d.f */
rtl/core/mmn_pkg.sv
rtl/core/mmn_ram.sv
rtl/core/mmn_div.sv
rtl/core/mmn_ctrl.sv
rtl/core/mmn_datapath.sv
rtl/core/min_max_normalize_2d.sv
tb/sv/tb_top.sv
